@@ rtl/core/spq_pkg.sv @@
// Shared types, register indexes and helper functions for the sprite quad expander.
// No dependencies; every other file of the block imports this package.
package spq_pkg;

    localparam int CfgIndexW = 8;
    localparam int CfgDataW = 32;
    localparam int SpriteWidthW = 31;
    localparam int ScaleW = 16;
    localparam int ProdW = ScaleW + SpriteWidthW;
    localparam int HalfShift = 9;
    localparam int WideW = 40;
    localparam int VertCntW = 3;
    localparam logic [VertCntW-1:0] LAST_VERTEX = 3'd5;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_SPRITE_WIDTH = 8'd0,
        CFG_GLOBAL_SCALE = 8'd1,
        CFG_PER_PARTICLE_MODE = 8'd2,
        CFG_TEX_U_LEFT = 8'd3,
        CFG_TEX_V_BOTTOM = 8'd4,
        CFG_TEX_U_RIGHT = 8'd5,
        CFG_TEX_V_TOP = 8'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        size_scale;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [7:0]         alpha_in;
        logic               alive;
    } particle_t;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
        logic [7:0]         alpha_out;
        logic               last_vertex;
    } vertex_t;

    typedef struct packed {
        logic [SpriteWidthW-1:0] sprite_width;
        logic [ScaleW-1:0]       global_scale;
        logic                    per_particle_mode;
        logic [15:0]             tex_u_left;
        logic [15:0]             tex_v_bottom;
        logic [15:0]             tex_u_right;
        logic [15:0]             tex_v_top;
    } cfg_t;

    typedef struct packed {
        logic [31:0] x_left;
        logic [31:0] x_right;
        logic [31:0] y_bottom;
        logic [31:0] y_top;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } quad_t;

    function automatic logic [31:0] sat32(input logic signed [WideW-1:0] v);
        logic [31:0] r;
        if (v > 40'sh007FFFFFFF) begin
            r = 32'h7FFFFFFF;
        end else if (v < -40'sh0080000000) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic corner_right(input logic [VertCntW-1:0] idx);
        logic r;
        case (idx)
            3'd1, 3'd2, 3'd3: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic corner_top(input logic [VertCntW-1:0] idx);
        logic r;
        case (idx)
            3'd2, 3'd3, 3'd4: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/sprite_quad_expander.sv @@
// Top level of the sprite quad expander: configuration registers and the
// front, queue and back instances. Depends on spq_pkg and the spq_* modules.

// Each live particle becomes six vertices (two triangles of a square quad), emitted
// one per cycle on the single vertex output port while out_ready holds, which sets the
// pace of a steady stream of live particles. Dead particles are taken at one per cycle
// while in_ready is high and produce nothing. The front end registers the multiply and
// forms the edge sums from that register, and a two-entry queue lets it keep
// accepting while the back end is still emitting an earlier quad. The
// configuration port is always ready; write it only while the block is idle.
module sprite_quad_expander
    import spq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  particle_t            in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vertex_t              out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    cfg_t  cfg_reg;
    logic  push_valid;
    logic  push_ready;
    quad_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    quad_t pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sprite_width <= 31'd65536;
            cfg_reg.global_scale <= 16'd256;
            cfg_reg.per_particle_mode <= 1'b1;
            cfg_reg.tex_u_left <= 16'd0;
            cfg_reg.tex_v_bottom <= 16'd0;
            cfg_reg.tex_u_right <= 16'hFFFF;
            cfg_reg.tex_v_top <= 16'hFFFF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SPRITE_WIDTH: cfg_reg.sprite_width <= cfg_data[SpriteWidthW-1:0];
                CFG_GLOBAL_SCALE: cfg_reg.global_scale <= cfg_data[ScaleW-1:0];
                CFG_PER_PARTICLE_MODE: cfg_reg.per_particle_mode <= cfg_data[0];
                CFG_TEX_U_LEFT: cfg_reg.tex_u_left <= cfg_data[15:0];
                CFG_TEX_V_BOTTOM: cfg_reg.tex_v_bottom <= cfg_data[15:0];
                CFG_TEX_U_RIGHT: cfg_reg.tex_u_right <= cfg_data[15:0];
                CFG_TEX_V_TOP: cfg_reg.tex_v_top <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    spq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    spq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    spq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/core/spq_front.sv @@
// Front end: accepts particles, drops dead ones, computes the half-size product
// and the four saturated edge coordinates. Depends on spq_pkg.
module spq_front
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  particle_t in_data,
    output logic      push_valid,
    input  logic      push_ready,
    output quad_t     push_data
);

    logic              a_valid_reg;
    logic [ProdW-1:0]  a_prod_reg;
    logic [31:0]       a_pos_x_reg;
    logic [31:0]       a_pos_y_reg;
    logic [31:0]       a_rgba_reg;
    logic [ScaleW-1:0] scale;
    logic              load;

    logic signed [WideW-1:0] hs;
    logic signed [WideW-1:0] px;
    logic signed [WideW-1:0] py;

    assign scale = cfg.per_particle_mode ? in_data.size_scale : cfg.global_scale;
    assign in_ready = !a_valid_reg || push_ready;
    assign load = in_valid && in_ready && in_data.alive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid && in_data.alive;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_prod_reg <= ProdW'(scale) * ProdW'(cfg.sprite_width);
            a_pos_x_reg <= in_data.pos_x;
            a_pos_y_reg <= in_data.pos_y;
            a_rgba_reg <= {in_data.red_in, in_data.green_in, in_data.blue_in,
                           in_data.alpha_in};
        end
    end

    assign hs = $signed(WideW'(a_prod_reg[ProdW-1:HalfShift]));
    assign px = $signed({{(WideW-32){a_pos_x_reg[31]}}, a_pos_x_reg});
    assign py = $signed({{(WideW-32){a_pos_y_reg[31]}}, a_pos_y_reg});

    assign push_valid = a_valid_reg;
    assign push_data.x_left = sat32(px - hs);
    assign push_data.x_right = sat32(px + hs);
    assign push_data.y_bottom = sat32(py - hs);
    assign push_data.y_top = sat32(py + hs);
    assign push_data.red = a_rgba_reg[31:24];
    assign push_data.green = a_rgba_reg[23:16];
    assign push_data.blue = a_rgba_reg[15:8];
    assign push_data.alpha = a_rgba_reg[7:0];

endmodule

@@ rtl/core/spq_queue.sv @@
// Two-entry queue of expanded quads between the front and back ends.
// Depends on spq_pkg.
module spq_queue
    import spq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  quad_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output quad_t pop_data
);

    quad_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/spq_back.sv @@
// Back end: walks the six vertices of the quad at the queue head into an
// output register. Depends on spq_pkg.
module spq_back
    import spq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  quad_t   pop_data,
    output logic    out_valid,
    input  logic    out_ready,
    output vertex_t out_data
);

    logic                out_valid_reg;
    vertex_t             out_data_reg;
    logic [VertCntW-1:0] cnt_reg;
    logic                emit;
    logic                right;
    logic                top;

    assign emit = pop_valid && (!out_valid_reg || out_ready);
    assign pop_ready = emit && (cnt_reg == LAST_VERTEX);
    assign right = corner_right(cnt_reg);
    assign top = corner_top(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= pop_valid;
            end
            if (emit)
            begin
                cnt_reg <= (cnt_reg == LAST_VERTEX) ? '0 : cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.vert_x <= right ? pop_data.x_right : pop_data.x_left;
            out_data_reg.vert_y <= top ? pop_data.y_top : pop_data.y_bottom;
            out_data_reg.tex_u <= right ? cfg.tex_u_right : cfg.tex_u_left;
            out_data_reg.tex_v <= top ? cfg.tex_v_top : cfg.tex_v_bottom;
            out_data_reg.red_out <= pop_data.red;
            out_data_reg.green_out <= pop_data.green;
            out_data_reg.blue_out <= pop_data.blue;
            out_data_reg.alpha_out <= pop_data.alpha;
            out_data_reg.last_vertex <= cnt_reg == LAST_VERTEX;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

@@ dv/tb_sprite_quad_expander.sv @@
// Testbench for sprite_quad_expander: directed and random particles checked against a
// built-in quad predictor, with random idling on both channels and a long output stall.
// Depends on spq_pkg and the sprite_quad_expander RTL.
module tb_sprite_quad_expander;
    import spq_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int MAX_REPORTS = 10;
    localparam longint LIMIT_TIME = 2000000;
    localparam logic [CfgIndexW-1:0] FIRST_UNUSED_INDEX = 8'd7;
    localparam logic [CfgIndexW-1:0] LAST_UNUSED_INDEX = 8'hFF;
    localparam logic [5:0] RIGHT_CORNERS = 6'b001110;
    localparam logic [5:0] TOP_CORNERS = 6'b011100;
    localparam logic signed [48:0] Q16_MAX = 49'sd2147483647;
    localparam logic signed [48:0] Q16_MIN = -49'sd2147483648;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    particle_t            in_data;
    logic                 out_valid;
    logic                 out_ready;
    vertex_t              out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    cfg_t    cfg_shadow;
    vertex_t vertex_q[$];
    int      failures;
    int      hold_left;
    int      stall_left;
    bit      hold_pending;
    bit      quiet;

    sprite_quad_expander u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic cfg_t make_cfg(input logic [30:0] sw, input logic [15:0] gs,
                                      input logic mode, input logic [15:0] ul,
                                      input logic [15:0] vb, input logic [15:0] ur,
                                      input logic [15:0] vt);
        cfg_t c;
        c.sprite_width = sw;
        c.global_scale = gs;
        c.per_particle_mode = mode;
        c.tex_u_left = ul;
        c.tex_v_bottom = vb;
        c.tex_u_right = ur;
        c.tex_v_top = vt;
        return c;
    endfunction

    function automatic particle_t make_particle(input logic [31:0] x, input logic [31:0] y,
                                                input logic [15:0] scale,
                                                input logic [31:0] rgba, input logic alive);
        particle_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.size_scale = scale;
        {p.red_in, p.green_in, p.blue_in, p.alpha_in} = rgba;
        p.alive = alive;
        return p;
    endfunction

    function automatic logic [31:0] clamp_q16(input logic signed [48:0] v);
        logic [31:0] r;
        if (v > Q16_MAX)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < Q16_MIN)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic void update_shadow(input logic [CfgIndexW-1:0] idx,
                                          input logic [CfgDataW-1:0] data);
        case (idx)
            CFG_SPRITE_WIDTH:      cfg_shadow.sprite_width = data[30:0];
            CFG_GLOBAL_SCALE:      cfg_shadow.global_scale = data[15:0];
            CFG_PER_PARTICLE_MODE: cfg_shadow.per_particle_mode = data[0];
            CFG_TEX_U_LEFT:        cfg_shadow.tex_u_left = data[15:0];
            CFG_TEX_V_BOTTOM:      cfg_shadow.tex_v_bottom = data[15:0];
            CFG_TEX_U_RIGHT:       cfg_shadow.tex_u_right = data[15:0];
            CFG_TEX_V_TOP:         cfg_shadow.tex_v_top = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_quad(input particle_t p);
        logic [15:0]        scale;
        logic [46:0]        prod;
        logic signed [48:0] half;
        logic signed [48:0] px;
        logic signed [48:0] py;
        logic [31:0]        x_left;
        logic [31:0]        x_right;
        logic [31:0]        y_bottom;
        logic [31:0]        y_top;
        vertex_t            v;
        if (!p.alive)
        begin
            return;
        end
        scale = cfg_shadow.per_particle_mode ? p.size_scale : cfg_shadow.global_scale;
        prod = scale * cfg_shadow.sprite_width;
        half = {11'd0, prod[46:9]};
        px = {{17{p.pos_x[31]}}, p.pos_x};
        py = {{17{p.pos_y[31]}}, p.pos_y};
        x_left = clamp_q16(px - half);
        x_right = clamp_q16(px + half);
        y_bottom = clamp_q16(py - half);
        y_top = clamp_q16(py + half);
        for (int k = 0; k < 6; k++)
        begin
            v.vert_x = RIGHT_CORNERS[k] ? x_right : x_left;
            v.vert_y = TOP_CORNERS[k] ? y_top : y_bottom;
            v.tex_u = RIGHT_CORNERS[k] ? cfg_shadow.tex_u_right : cfg_shadow.tex_u_left;
            v.tex_v = TOP_CORNERS[k] ? cfg_shadow.tex_v_top : cfg_shadow.tex_v_bottom;
            v.red_out = p.red_in;
            v.green_out = p.green_in;
            v.blue_out = p.blue_in;
            v.alpha_out = p.alpha_in;
            v.last_vertex = (k == 5);
            vertex_q.push_back(v);
        end
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    task automatic check_vertex(input vertex_t got);
        vertex_t want;
        if (vertex_q.size() == 0)
        begin
            note_failure($sformatf("vertex with nothing pending: %h", got));
            return;
        end
        want = vertex_q.pop_front();
        if (got.vert_x !== want.vert_x)
            note_failure($sformatf("vert_x exp %h got %h", want.vert_x, got.vert_x));
        if (got.vert_y !== want.vert_y)
            note_failure($sformatf("vert_y exp %h got %h", want.vert_y, got.vert_y));
        if (got.tex_u !== want.tex_u)
            note_failure($sformatf("tex_u exp %h got %h", want.tex_u, got.tex_u));
        if (got.tex_v !== want.tex_v)
            note_failure($sformatf("tex_v exp %h got %h", want.tex_v, got.tex_v));
        if (got.red_out !== want.red_out)
            note_failure($sformatf("red_out exp %h got %h", want.red_out, got.red_out));
        if (got.green_out !== want.green_out)
            note_failure($sformatf("green_out exp %h got %h", want.green_out, got.green_out));
        if (got.blue_out !== want.blue_out)
            note_failure($sformatf("blue_out exp %h got %h", want.blue_out, got.blue_out));
        if (got.alpha_out !== want.alpha_out)
            note_failure($sformatf("alpha_out exp %h got %h", want.alpha_out, got.alpha_out));
        if (got.last_vertex !== want.last_vertex)
            note_failure($sformatf("last_vertex exp %b got %b", want.last_vertex,
                                   got.last_vertex));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_vertex(out_data);
            end
            if (hold_pending)
            begin
                hold_left = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_particle(input particle_t p);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_quad(p);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        update_shadow(idx, data);
    endtask

    // Upper data bits are random so that writes also exercise truncation to the register width.
    task automatic apply_settings(input cfg_t c);
        logic [CfgDataW-1:0] d;
        d = $urandom;
        d[30:0] = c.sprite_width;
        write_reg(CFG_SPRITE_WIDTH, d);
        d = $urandom;
        d[15:0] = c.global_scale;
        write_reg(CFG_GLOBAL_SCALE, d);
        d = $urandom;
        d[0] = c.per_particle_mode;
        write_reg(CFG_PER_PARTICLE_MODE, d);
        d = $urandom;
        d[15:0] = c.tex_u_left;
        write_reg(CFG_TEX_U_LEFT, d);
        d = $urandom;
        d[15:0] = c.tex_v_bottom;
        write_reg(CFG_TEX_V_BOTTOM, d);
        d = $urandom;
        d[15:0] = c.tex_u_right;
        write_reg(CFG_TEX_U_RIGHT, d);
        d = $urandom;
        d[15:0] = c.tex_v_top;
        write_reg(CFG_TEX_V_TOP, d);
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(CfgIndexW'($urandom_range(FIRST_UNUSED_INDEX, LAST_UNUSED_INDEX)),
                      $urandom);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        logic [31:0] c;
        case ($urandom_range(0, 5))
            0: c = $urandom;
            1: c = 32'h7FFF_FFFF - $urandom_range(0, 32'h0004_0000);
            2: c = 32'h8000_0000 + $urandom_range(0, 32'h0004_0000);
            default: c = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] rand_scale();
        logic [15:0] s;
        case ($urandom_range(0, 7))
            0: s = 16'h0000;
            1: s = 16'hFFFF;
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic [15:0] rand_tex();
        logic [15:0] t;
        case ($urandom_range(0, 5))
            0: t = 16'h0000;
            1: t = 16'hFFFF;
            default: t = 16'($urandom);
        endcase
        return t;
    endfunction

    function automatic cfg_t rand_cfg();
        logic [30:0] sw;
        case ($urandom_range(0, 9))
            0: sw = '0;
            1: sw = 31'h7FFF_FFFF;
            2: sw = 31'($urandom);
            default: sw = 31'($urandom_range(0, 32'h0004_0000));
        endcase
        return make_cfg(sw, rand_scale(), 1'($urandom_range(0, 1)), rand_tex(), rand_tex(),
                        rand_tex(), rand_tex());
    endfunction

    function automatic particle_t rand_particle();
        return make_particle(rand_coord(), rand_coord(), rand_scale(), $urandom,
                             $urandom_range(0, 3) != 0);
    endfunction

    task automatic test_reset_defaults();
        send_particle(make_particle(32'h0000_0000, 32'h0000_0000, 16'h0100, 32'h11223344, 1'b1));
        send_particle(make_particle(32'h1234_5678, 32'h8765_4321, 16'hFFFF, 32'hFFFFFFFF, 1'b0));
        send_particle(make_particle(32'h0001_0000, 32'hFFFF_0000, 16'h0000, 32'hFF00FF00, 1'b1));
        send_particle(make_particle(32'hFFFF_FFFF, 32'h0000_0001, 16'h0080, 32'h00FF00FF, 1'b1));
        settle();
    endtask

    task automatic test_corner_saturation();
        apply_settings(make_cfg(31'h7FFF_FFFF, 16'h0100, 1'b1, 16'h0000, 16'h0000,
                                16'hFFFF, 16'hFFFF));
        send_particle(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1));
        send_particle(make_particle(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 32'h00000000, 1'b1));
        send_particle(make_particle(32'h0000_0000, 32'h0000_0000, 16'h0001, 32'h80808080, 1'b1));
        send_particle(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 32'h7F7F7F7F, 1'b1));
        settle();
        apply_settings(make_cfg('0, 16'h0100, 1'b1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
        send_particle(make_particle(32'h0042_0000, 32'hFFBE_0000, 16'hFFFF, 32'h01020304, 1'b1));
        settle();
    endtask

    task automatic test_uniform_mode();
        apply_settings(make_cfg(31'h0001_0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000,
                                16'hFFFF, 16'hFFFF));
        send_particle(make_particle(32'h0010_0000, 32'h0020_0000, 16'h0000, 32'hA0B0C0D0, 1'b1));
        send_particle(make_particle(32'h7FF0_0000, 32'h8010_0000, 16'hFFFF, 32'h0A0B0C0D, 1'b1));
        send_particle(make_particle(32'h0000_0000, 32'h0000_0000, 16'h1234, 32'h55555555, 1'b0));
        settle();
        apply_settings(make_cfg(31'h0003_0000, 16'h0000, 1'b0, 16'h0000, 16'h0000,
                                16'hFFFF, 16'hFFFF));
        send_particle(make_particle(32'h0005_8000, 32'hFFFA_8000, 16'hFFFF, 32'hCAFEF00D, 1'b1));
        settle();
    endtask

    task automatic test_texture_edges();
        apply_settings(make_cfg(31'h0002_0000, 16'h0100, 1'b1, 16'hFFFF, 16'hFFFF,
                                16'h0000, 16'h0000));
        send_particle(make_particle(32'h0001_0000, 32'h0002_0000, 16'h0200, 32'h10203040, 1'b1));
        send_particle(make_particle(32'hFFFE_0000, 32'hFFFF_0000, 16'h0040, 32'h50607080, 1'b1));
        settle();
    endtask

    task automatic test_unknown_index();
        write_reg(FIRST_UNUSED_INDEX, 32'hFFFF_FFFF);
        write_reg(LAST_UNUSED_INDEX, 32'h0000_0000);
        cfg_valid <= 1'b0;
        send_particle(make_particle(32'h0003_0000, 32'h0004_0000, 16'h0180, 32'h99AABBCC, 1'b1));
        settle();
    endtask

    // The output side holds off while particles keep arriving, so the queue fills and
    // in_ready has to drop until the stall ends.
    task automatic test_back_pressure();
        apply_settings(make_cfg(31'h0001_0000, 16'h0100, 1'b1, 16'h0100, 16'h0200,
                                16'hFE00, 16'hFD00));
        quiet = 1'b1;
        hold_pending = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            send_particle(make_particle(rand_coord(), rand_coord(), rand_scale(), $urandom, 1'b1));
        end
        settle();
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            quiet = (ph == RANDOM_PHASES - 1) || (ph == 3);
            apply_settings(rand_cfg());
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_particle(rand_particle());
            end
            settle();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        failures = 0;
        hold_left = 0;
        stall_left = 0;
        hold_pending = 1'b0;
        quiet = 1'b0;
        cfg_shadow = make_cfg(31'h0001_0000, 16'h0100, 1'b1, 16'h0000, 16'h0000,
                              16'hFFFF, 16'hFFFF);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_corner_saturation();
        test_uniform_mode();
        test_texture_edges();
        test_unknown_index();
        test_back_pressure();
        test_random_traffic();
        if (vertex_q.size() != 0)
        begin
            note_failure($sformatf("%0d vertices never arrived", vertex_q.size()));
        end
        if (failures == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #(LIMIT_TIME);
        $display("simulation failed");
        $finish;
    end

endmodule
